### hw/rtl/tksl_pkg.sv
package tksl_pkg;

  // List size and the field widths of a request and a result.
  localparam int LIST_DEPTH = 64;
  localparam int OP_W       = 2;
  localparam int SCORE_W    = 16;
  localparam int ID_W       = 20;
  localparam int RANK_W     = 6;
  localparam int FILL_W     = 7;

  // Entry count holds 0 to LIST_DEPTH inclusive.
  localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
  // Width that holds both a rank and a count for comparisons.
  localparam int CMP_W   = ((RANK_W > COUNT_W) ? RANK_W : COUNT_W) + 1;

  // Read select tree: cells are gathered in groups, with one register per group.
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_CNT  = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // One held (score, item id) pair.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           item_id;
  } entry_t;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic shift_en;  // an insert is being taken this cycle
    logic occupied;  // this cell holds a live entry
    logic prev_ge;   // left neighbor keeps its entry
  } cell_ctl_t;

endpackage

### hw/rtl/tksl_in_if.sv
interface tksl_in_if import tksl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [SCORE_W-1:0] score;
  logic [ID_W-1:0]           item_id;
  logic [RANK_W-1:0]         rank;

  modport source (output valid, op, score, item_id, rank, input ready);
  modport sink (input valid, op, score, item_id, rank, output ready);
  modport monitor (input valid, ready, op, score, item_id, rank);
endinterface

### hw/rtl/tksl_out_if.sv
interface tksl_out_if import tksl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] out_score;
  logic [ID_W-1:0]           out_item_id;
  logic                      out_valid;
  logic                      accepted;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, out_score, out_item_id, out_valid, accepted, fill_count,
                  input ready);
  modport sink (input valid, out_score, out_item_id, out_valid, accepted, fill_count,
                output ready);
  modport monitor (input valid, ready, out_score, out_item_id, out_valid, accepted,
                   fill_count);
endinterface

### hw/rtl/tksl_cell.sv
module tksl_cell import tksl_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    cand,
  input  entry_t    prev,
  output entry_t    cur,
  output logic      ge
);

  entry_t entry;

  // A live entry with a score at least the candidate's stays in place.
  assign ge  = ctl.occupied && ($signed(entry.score) >= $signed(cand.score));
  assign cur = entry;

  // Otherwise the cell takes the candidate if it is the insert point,
  // or the left neighbor's entry if it lies past it.
  always_ff @(posedge clk) begin
    if (ctl.shift_en && !ge) begin
      entry <= ctl.prev_ge ? cand : prev;
    end
  end

endmodule

### hw/rtl/tksl_read_sel.sv
module tksl_read_sel import tksl_pkg::*; (
  input  logic              clk,
  input  entry_t            entries [LIST_DEPTH],
  input  logic [RANK_W-1:0] rank,
  output entry_t            sel
);

  entry_t masked [GROUP_CNT*GROUP_SIZE];
  entry_t grp_next [GROUP_CNT];
  entry_t grp [GROUP_CNT];

  // Each cell contributes its entry only when its position matches the rank.
  for (genvar j = 0; j < GROUP_CNT * GROUP_SIZE; j++) begin : g_mask
    if (j < LIST_DEPTH) begin : g_live
      assign masked[j] = (CMP_W'(rank) == CMP_W'(j)) ? entries[j] : '0;
    end else begin : g_pad
      assign masked[j] = '0;
    end
  end

  // First level: OR within each group.
  always_comb begin
    for (int g = 0; g < GROUP_CNT; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_next[g] = grp_next[g] | masked[g*GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
  end

  // Second level: OR across the registered groups.
  always_comb begin
    sel = '0;
    for (int g = 0; g < GROUP_CNT; g++) begin
      sel = sel | grp[g];
    end
  end

endmodule

### hw/rtl/top_k_sorted_list.sv
// Sorted top-K list: holds the LIST_DEPTH best (score, item id) pairs in
// descending score order, in a row of cells that all compare against an
// incoming candidate and shift right past the insert point together.
// Equal scores keep arrival order. Every request yields exactly one result.
// Insert, clear and no-op results are registered straight from the request;
// a read's result follows the registered two-level rank select that gathers
// the addressed cell. Requests are handled one at a time. A new request can
// be taken in the same cycle as the previous result leaves the output
// register, so inserts, clears and no-ops can follow at one per cycle while
// the result side is ready, and a read holds off the next request in S_READ.
module top_k_sorted_list import tksl_pkg::*; (
  input logic         clk,
  input logic         rst,
  tksl_in_if.sink     in_ch,
  tksl_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic                 rd_valid;

  logic                 res_valid;
  logic signed [SCORE_W-1:0] res_score;
  logic [ID_W-1:0]      res_item_id;
  logic                 res_out_valid;
  logic                 res_accepted;
  logic [FILL_W-1:0]    res_fill;

  logic                 take;
  logic                 full;
  logic                 ins_take;
  op_t                  op;
  entry_t               cand;
  entry_t               cell_q [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_ge;
  cell_ctl_t            cell_ctl [LIST_DEPTH];
  entry_t               rd_entry;

  // Handshake: a request is taken when idle and the result slot frees up.
  assign in_ch.ready = (state == S_IDLE) && (!res_valid || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.op);

  assign cand.score   = in_ch.score;
  assign cand.item_id = in_ch.item_id;

  // A full list takes the candidate only if it beats the last entry.
  assign full     = (count == COUNT_W'(LIST_DEPTH));
  assign ins_take = take && (op == OP_INSERT) && (!full || !cell_ge[LIST_DEPTH-1]);

  // Row of cells.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].shift_en = ins_take;
    assign cell_ctl[i].occupied = (COUNT_W'(i) < count);
    if (i == 0) begin : g_first
      assign cell_ctl[i].prev_ge = 1'b1;
      tksl_cell u_cell (
        .clk  (clk),
        .ctl  (cell_ctl[i]),
        .cand (cand),
        .prev (cand),
        .cur  (cell_q[i]),
        .ge   (cell_ge[i])
      );
    end else begin : g_rest
      assign cell_ctl[i].prev_ge = cell_ge[i-1];
      tksl_cell u_cell (
        .clk  (clk),
        .ctl  (cell_ctl[i]),
        .cand (cand),
        .prev (cell_q[i-1]),
        .cur  (cell_q[i]),
        .ge   (cell_ge[i])
      );
    end
  end

  // Rank select for reads.
  tksl_read_sel u_read_sel (
    .clk     (clk),
    .entries (cell_q),
    .rank    (in_ch.rank),
    .sel     (rd_entry)
  );

  // Entry count update.
  always_comb begin
    count_next = count;
    if (take) begin
      case (op)
        OP_INSERT: begin
          if (ins_take && !full) begin
            count_next = count + COUNT_W'(1);
          end
        end
        OP_CLEAR: count_next = '0;
        default:  count_next = count;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (take && (op == OP_READ)) begin
            state     <= S_READ;
            res_valid <= 1'b0;
          end else if (take) begin
            res_valid <= 1'b1;
          end else if (out_ch.ready) begin
            res_valid <= 1'b0;
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          res_valid <= 1'b0;
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && take) begin
      rd_valid      <= (CMP_W'(in_ch.rank) < CMP_W'(count));
      res_score     <= '0;
      res_item_id   <= '0;
      res_out_valid <= 1'b0;
      res_accepted  <= ins_take;
      res_fill      <= FILL_W'(count_next);
    end else if (state == S_READ) begin
      res_score     <= rd_valid ? rd_entry.score : '0;
      res_item_id   <= rd_valid ? rd_entry.item_id : '0;
      res_out_valid <= rd_valid;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.out_score   = res_score;
  assign out_ch.out_item_id = res_item_id;
  assign out_ch.out_valid   = res_out_valid;
  assign out_ch.accepted    = res_accepted;
  assign out_ch.fill_count  = res_fill;

endmodule

### hw/rtl/tksl_checker.sv
module tksl_checker import tksl_pkg::*; (
  input logic         clk,
  input logic         rst,
  tksl_in_if.sink     in_mon,
  tksl_out_if.source  out_mon
);

  // A pending result stays until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_mon.valid && !out_mon.ready |=> out_mon.valid)
    else $error("result dropped while stalled");

  // The list never reports more entries than it can hold.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_mon.valid |-> (CMP_W'(out_mon.fill_count) <= CMP_W'(LIST_DEPTH)))
    else $error("fill count above list depth");

  // Anything but a hit on a read carries a zero entry.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_mon.valid && !out_mon.out_valid |->
      (out_mon.out_score == '0) && (out_mon.out_item_id == '0))
    else $error("entry fields set without a valid read");

  // An accepted insert is never also a read hit, and leaves a nonempty list.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    out_mon.valid && out_mon.accepted |->
      !out_mon.out_valid && (out_mon.fill_count != '0))
    else $error("accepted insert with inconsistent result");

  // After a request is taken, the input is ready again only with a result pending.
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    in_mon.valid && in_mon.ready |=> !in_mon.ready || out_mon.valid)
    else $error("request taken without a result");

endmodule

bind top_k_sorted_list tksl_checker u_tksl_checker (
  .clk     (clk),
  .rst     (rst),
  .in_mon  (in_ch),
  .out_mon (out_ch)
);

### tb/sv/testbench.sv
module testbench;
  import tksl_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Requests with an opcode other than no-op that the random part aims for.
  localparam int LIVE_TARGET = 1350;
  // Cycle window in which neither side idles.
  localparam int CALM_START = 600;
  localparam int CALM_END   = 1400;

  typedef struct {
    op_t                       op;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           item_id;
    logic [RANK_W-1:0]         rank;
  } list_req_t;

  typedef struct {
    logic signed [SCORE_W-1:0] out_score;
    logic [ID_W-1:0]           out_item_id;
    logic                      out_valid;
    logic                      accepted;
    logic [FILL_W-1:0]         fill_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tksl_in_if  in_ch ();
  tksl_out_if out_ch ();

  top_k_sorted_list u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted list contents, in rank order.
  logic signed [SCORE_W-1:0] held_scores [LIST_DEPTH];
  logic [ID_W-1:0]           held_ids [LIST_DEPTH];
  int                        held_count;

  list_req_t    pending_reqs [$];
  list_result_t expected_results [$];
  list_req_t    next_req;

  int live_reqs;
  int cycle_no;
  int stall_cycles;
  int fail_count;
  int reqs_taken;
  int results_checked;
  int full_rejects;
  int hit_reads;
  int clears_seen;
  bit calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the predicted list and returns the result it should give.
  function automatic list_result_t list_step(logic [OP_W-1:0] op,
                                             logic signed [SCORE_W-1:0] score,
                                             logic [ID_W-1:0] item_id,
                                             logic [RANK_W-1:0] rank);
    list_result_t r;
    int pos;
    int last;
    bit take;
    r = '{out_score: '0, out_item_id: '0, out_valid: 1'b0, accepted: 1'b0,
          fill_count: '0};
    case (op)
      OP_INSERT: begin
        take = 1'b1;
        if (held_count >= LIST_DEPTH) begin
          // A full list only takes a score strictly above its last one.
          if (!(held_scores[LIST_DEPTH-1] < score)) begin
            take = 1'b0;
            full_rejects++;
          end
          last = LIST_DEPTH - 1;
        end else begin
          last = held_count;
          held_count++;
        end
        if (take) begin
          // Equal scores keep the older entry ahead.
          pos = 0;
          while (pos < last && held_scores[pos] >= score) pos++;
          for (int k = last; k > pos; k--) begin
            held_scores[k] = held_scores[k-1];
            held_ids[k]    = held_ids[k-1];
          end
          held_scores[pos] = score;
          held_ids[pos]    = item_id;
        end
        r.accepted = take;
      end
      OP_READ: begin
        if (int'(rank) < held_count) begin
          r.out_score   = held_scores[rank];
          r.out_item_id = held_ids[rank];
          r.out_valid   = 1'b1;
          hit_reads++;
        end
      end
      OP_CLEAR: begin
        held_count = 0;
        clears_seen++;
      end
      default: begin
      end
    endcase
    r.fill_count = held_count[FILL_W-1:0];
    return r;
  endfunction

  function automatic void push_req(op_t op, logic signed [SCORE_W-1:0] score,
                                   logic [ID_W-1:0] item_id, logic [RANK_W-1:0] rank);
    list_req_t q;
    q.op      = op;
    q.score   = score;
    q.item_id = item_id;
    q.rank    = rank;
    pending_reqs.push_back(q);
    if (op != OP_NOP) live_reqs++;
  endfunction

  // Score styles: full range, a narrow band that forces ties, or the edge values.
  function automatic logic signed [SCORE_W-1:0] pick_score(int style);
    logic signed [SCORE_W-1:0] s;
    case (style)
      0: s = SCORE_W'($urandom);
      1: s = SCORE_W'($signed($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(3))
          0: s = 16'sh8000;
          1: s = 16'sh7FFF;
          2: s = -16'sd1;
          default: s = 16'sd0;
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", what);
  endtask

  // Request driver: a new request goes out once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        next_req = pending_reqs.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.op      <= next_req.op;
        in_ch.score   <= next_req.score;
        in_ch.item_id <= next_req.item_id;
        in_ch.rank    <= next_req.rank;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Every accepted request updates the predicted list.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(list_step(in_ch.op, in_ch.score, in_ch.item_id,
                                           in_ch.rank));
      reqs_taken++;
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: score %0d id %0h valid %0b",
                               out_ch.out_score, out_ch.out_item_id, out_ch.out_valid));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.out_score !== want.out_score || out_ch.out_item_id !== want.out_item_id ||
            out_ch.out_valid !== want.out_valid || out_ch.accepted !== want.accepted ||
            out_ch.fill_count !== want.fill_count) begin
          note_failure($sformatf({"result %0d: expected score %0d id %0h valid %0b acc %0b ",
                                  "fill %0d, got score %0d id %0h valid %0b acc %0b fill %0d"},
                                 results_checked, want.out_score, want.out_item_id,
                                 want.out_valid, want.accepted, want.fill_count,
                                 out_ch.out_score, out_ch.out_item_id, out_ch.out_valid,
                                 out_ch.accepted, out_ch.fill_count));
        end
      end
    end
  end

  // Cycle count, calm window and the stall watchdog.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    calm     <= (cycle_no >= CALM_START) && (cycle_no < CALM_END);
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Run stalled for %0d cycles with %0d results outstanding.", stall_cycles,
             expected_results.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int n_ins;
    int style;
    int n_reads;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_NOP;
    in_ch.score   = '0;
    in_ch.item_id = '0;
    in_ch.rank    = '0;
    out_ch.ready  = 1'b0;
    held_count = 0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      held_scores[i] = '0;
      held_ids[i]    = '0;
    end

    // Directed: empty reads, no-ops, extreme scores and ids, ties, clear.
    push_req(OP_READ, 16'sd0, 20'h0, 6'd0);
    push_req(OP_NOP, 16'shFFFF, 20'hFFFFF, 6'h3F);
    push_req(OP_INSERT, 16'sd0, 20'h00000, 6'd0);
    push_req(OP_INSERT, 16'sh7FFF, 20'hFFFFF, 6'd0);
    push_req(OP_INSERT, 16'sh8000, 20'h12345, 6'd0);
    push_req(OP_INSERT, 16'sd0, 20'h00007, 6'd0);
    push_req(OP_INSERT, 16'sh7FFF, 20'hABCDE, 6'd0);
    for (int r = 0; r < 6; r++) push_req(OP_READ, 16'sd0, 20'h0, r[RANK_W-1:0]);
    push_req(OP_READ, 16'sd0, 20'h0, 6'h3F);
    push_req(OP_CLEAR, 16'sh7FFF, 20'hFFFFF, 6'h3F);
    push_req(OP_READ, 16'sd0, 20'h0, 6'd0);
    push_req(OP_INSERT, 16'sh8000, 20'h00001, 6'd0);
    push_req(OP_READ, 16'sd0, 20'h0, 6'd0);
    push_req(OP_READ, 16'sd0, 20'h0, 6'd1);
    push_req(OP_NOP, 16'sd0, 20'h0, 6'd0);
    push_req(OP_CLEAR, 16'sd0, 20'h0, 6'd0);

    // Random: mostly fill-and-probe episodes, some full-list scans and noise.
    while (live_reqs < LIVE_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(9) < 7) begin
            push_req(OP_CLEAR, pick_score(0), ID_W'($urandom), RANK_W'($urandom));
          end
          n_ins = ($urandom_range(1) == 0) ? $urandom_range(40, 110) : $urandom_range(1, 30);
          style = $urandom_range(2);
          for (int i = 0; i < n_ins; i++) begin
            push_req(OP_INSERT, pick_score(style), ID_W'($urandom), RANK_W'($urandom));
            if ($urandom_range(7) == 0) begin
              push_req(OP_READ, pick_score(0), ID_W'($urandom), RANK_W'($urandom));
            end
          end
          n_reads = $urandom_range(2, 12);
          for (int i = 0; i < n_reads; i++) begin
            push_req(OP_READ, pick_score(0), ID_W'($urandom), RANK_W'($urandom));
          end
        end
        6: begin
          // Top up to full with tie-heavy scores, then read every rank.
          for (int i = 0; i < 70; i++) begin
            push_req(OP_INSERT, pick_score(1), ID_W'($urandom), RANK_W'($urandom));
          end
          for (int r = 0; r < LIST_DEPTH; r++) begin
            push_req(OP_READ, pick_score(0), ID_W'($urandom), RANK_W'(r));
          end
        end
        7, 8: begin
          for (int i = 0; i < 10; i++) begin
            push_req(op_t'($urandom_range(3)), pick_score(0), ID_W'($urandom),
                     RANK_W'($urandom));
          end
        end
        default: begin
          push_req(OP_CLEAR, pick_score(0), ID_W'($urandom), RANK_W'($urandom));
          for (int i = 0; i < 4; i++) begin
            push_req(OP_READ, pick_score(0), ID_W'($urandom), RANK_W'($urandom));
          end
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: every request taken and every result seen, then a short settle.
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Checked %0d results from %0d requests over %0d cycles.", results_checked,
             reqs_taken, cycle_no);
    $display("Covered %0d full-list rejects, %0d in-range reads and %0d clears; %0d failures.",
             full_rejects, hit_reads, clears_seen, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tksl_pkg.sv
hw/rtl/tksl_in_if.sv
hw/rtl/tksl_out_if.sv
hw/rtl/tksl_cell.sv
hw/rtl/tksl_read_sel.sv
hw/rtl/top_k_sorted_list.sv
hw/rtl/tksl_checker.sv
tb/sv/testbench.sv
